### src/psc_pkg.sv
// shared types, constants and command struct of the path / obstacle segment collision core
// no dependencies
package psc_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int COORD_BITS   = 16;

  localparam int IDX_W   = $clog2(MAX_SEGMENTS);
  localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int SEG_W   = 4 * COORD_BITS;

  // segment test stages after the table read: differences, products, orientations, hit
  localparam int PIPE_DEPTH = 4;
  localparam int DRAIN_W    = $clog2(PIPE_DEPTH);

  localparam int CFG_W  = 7;
  localparam int SLOT_W = 6;
  localparam int HIT_W  = 6;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    OR_COLLINEAR = 2'd0,
    OR_CW        = 2'd1,
    OR_CCW       = 2'd2
  } orient_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } point_t;

  typedef struct packed {
    point_t a;
    point_t b;
  } seg_t;

  typedef struct packed {
    logic                     func;
    logic [SLOT_W-1:0]        slot;
    logic signed [15:0]       point_a_x;
    logic signed [15:0]       point_a_y;
    logic signed [15:0]       point_b_x;
    logic signed [15:0]       point_b_y;
  } in_item_t;

  typedef struct packed {
    logic             collision;
    logic [HIT_W-1:0] hit_index;
  } out_item_t;

  typedef struct packed {
    logic             start;     // clear hit tracker, latch query path
    logic             store;     // write the incoming segment into the table
    logic             issue;     // read one table entry into the test pipeline
    logic [IDX_W-1:0] raddr;
    logic             load_out;  // capture the result into the output register
  } psc_cmd_t;

endpackage

### src/psc_ram.sv
// generic single write port ram with registered read
// no dependencies
module psc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/psc_dp.sv
// datapath: segment table, pipelined orientation test, first hit tracker, result register
// depends on psc_pkg and psc_ram
module psc_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psc_pkg::psc_cmd_t   cmd_i,
  input  psc_pkg::in_item_t   in_data_i,
  output psc_pkg::out_item_t  out_data_o
);

  typedef logic signed [psc_pkg::DIFF_W-1:0]  diff_t;
  typedef logic signed [psc_pkg::PROD_W-1:0]  prod_t;
  typedef logic signed [psc_pkg::CROSS_W-1:0] cross_t;

  function automatic diff_t sub_c(input logic signed [psc_pkg::COORD_BITS-1:0] a,
                                  input logic signed [psc_pkg::COORD_BITS-1:0] b);
    diff_t ea;
    diff_t eb;
    ea = diff_t'(a);
    eb = diff_t'(b);
    return ea - eb;
  endfunction

  // q lies inside the bounding box of p and r
  function automatic logic in_box(input psc_pkg::point_t p, input psc_pkg::point_t q,
                                  input psc_pkg::point_t r);
    logic xok;
    logic yok;
    xok = (q.x <= p.x || q.x <= r.x) && (q.x >= p.x || q.x >= r.x);
    yok = (q.y <= p.y || q.y <= r.y) && (q.y >= p.y || q.y >= r.y);
    return xok && yok;
  endfunction

  psc_pkg::point_t pa_q;
  psc_pkg::point_t pb_q;

  logic [psc_pkg::SEG_W-1:0] wdata;
  logic [psc_pkg::SEG_W-1:0] rdata;
  logic                      we;
  psc_pkg::seg_t             seg;

  assign we    = cmd_i.store &&
                 (int'({1'b0, in_data_i.slot}) < psc_pkg::MAX_SEGMENTS);
  assign wdata = {in_data_i.point_a_x[psc_pkg::COORD_BITS-1:0],
                  in_data_i.point_a_y[psc_pkg::COORD_BITS-1:0],
                  in_data_i.point_b_x[psc_pkg::COORD_BITS-1:0],
                  in_data_i.point_b_y[psc_pkg::COORD_BITS-1:0]};

  psc_ram #(
    .WIDTH (psc_pkg::SEG_W),
    .DEPTH (psc_pkg::MAX_SEGMENTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (in_data_i.slot[psc_pkg::IDX_W-1:0]),
    .wdata_i (wdata),
    .raddr_i (cmd_i.raddr),
    .rdata_o (rdata)
  );

  assign seg = psc_pkg::seg_t'(rdata);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pa_q.x <= in_data_i.point_a_x[psc_pkg::COORD_BITS-1:0];
      pa_q.y <= in_data_i.point_a_y[psc_pkg::COORD_BITS-1:0];
      pb_q.x <= in_data_i.point_b_x[psc_pkg::COORD_BITS-1:0];
      pb_q.y <= in_data_i.point_b_y[psc_pkg::COORD_BITS-1:0];
    end
  end

  // stage valids and indexes travel alongside the data
  logic                     v1_q, v2_q, v3_q, v4_q;
  logic [psc_pkg::IDX_W-1:0] idx1_q, idx2_q, idx3_q, idx4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= cmd_i.raddr;
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    idx4_q <= idx3_q;
  end

  // orientation k: (m0 * m1) - (m2 * m3); k = 0,1 path vs segment ends, 2,3 segment vs path ends
  diff_t            m_d [4][4];
  diff_t            m_q [4][4];
  logic [3:0]       box_d;
  logic [3:0]       box2_q, box3_q, box4_q;

  always_comb begin
    m_d[0][0] = sub_c(pb_q.y, pa_q.y);
    m_d[0][1] = sub_c(seg.a.x, pb_q.x);
    m_d[0][2] = sub_c(pb_q.x, pa_q.x);
    m_d[0][3] = sub_c(seg.a.y, pb_q.y);
    m_d[1][0] = sub_c(pb_q.y, pa_q.y);
    m_d[1][1] = sub_c(seg.b.x, pb_q.x);
    m_d[1][2] = sub_c(pb_q.x, pa_q.x);
    m_d[1][3] = sub_c(seg.b.y, pb_q.y);
    m_d[2][0] = sub_c(seg.b.y, seg.a.y);
    m_d[2][1] = sub_c(pa_q.x, seg.b.x);
    m_d[2][2] = sub_c(seg.b.x, seg.a.x);
    m_d[2][3] = sub_c(pa_q.y, seg.b.y);
    m_d[3][0] = sub_c(seg.b.y, seg.a.y);
    m_d[3][1] = sub_c(pb_q.x, seg.b.x);
    m_d[3][2] = sub_c(seg.b.x, seg.a.x);
    m_d[3][3] = sub_c(pb_q.y, seg.b.y);
    box_d[0]  = in_box(pa_q, seg.a, pb_q);
    box_d[1]  = in_box(pa_q, seg.b, pb_q);
    box_d[2]  = in_box(seg.a, pa_q, seg.b);
    box_d[3]  = in_box(seg.a, pb_q, seg.b);
  end

  prod_t   p_q [4][2];
  cross_t  c_d [4];
  psc_pkg::orient_e o_d [4];
  psc_pkg::orient_e o_q [4];

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    box2_q <= box_d;
    box3_q <= box2_q;
    box4_q <= box3_q;
    for (int k = 0; k < 4; k++) begin
      p_q[k][0] <= m_q[k][0] * m_q[k][1];
      p_q[k][1] <= m_q[k][2] * m_q[k][3];
    end
    o_q <= o_d;
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      c_d[k] = cross_t'(p_q[k][0]) - cross_t'(p_q[k][1]);
      if (c_d[k] == '0) begin
        o_d[k] = psc_pkg::OR_COLLINEAR;
      end else if (c_d[k][psc_pkg::CROSS_W-1]) begin
        o_d[k] = psc_pkg::OR_CCW;
      end else begin
        o_d[k] = psc_pkg::OR_CW;
      end
    end
  end

  logic crossing;

  assign crossing = (o_q[0] != o_q[1] && o_q[2] != o_q[3]) ||
                    (o_q[0] == psc_pkg::OR_COLLINEAR && box4_q[0]) ||
                    (o_q[1] == psc_pkg::OR_COLLINEAR && box4_q[1]) ||
                    (o_q[2] == psc_pkg::OR_COLLINEAR && box4_q[2]) ||
                    (o_q[3] == psc_pkg::OR_COLLINEAR && box4_q[3]);

  logic                      found_q;
  logic [psc_pkg::IDX_W-1:0] hit_q;

  // entries arrive in slot order, so the first recorded hit is the lowest index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      hit_q   <= '0;
    end else if (cmd_i.start) begin
      found_q <= 1'b0;
      hit_q   <= '0;
    end else if (v4_q && crossing && !found_q) begin
      found_q <= 1'b1;
      hit_q   <= idx4_q;
    end
  end

  psc_pkg::out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.collision <= found_q;
      out_q.hit_index <= psc_pkg::HIT_W'(hit_q);
    end
  end

  assign out_data_o = out_q;

endmodule

### src/psc_ctrl.sv
// controller: transaction handshakes, segment count register, scan sequencer
// depends on psc_pkg
module psc_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [psc_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_func_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output psc_pkg::psc_cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RUN    = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e                       state_q, state_d;
  logic [psc_pkg::CFG_W-1:0]    seg_count_q;
  logic [psc_pkg::CNT_W-1:0]    n_q, n_d;
  logic [psc_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [psc_pkg::DRAIN_W-1:0]  drain_q, drain_d;
  logic                         out_valid_q, out_valid_d;
  logic                         accept;
  logic                         out_free;
  logic [psc_pkg::CNT_W-1:0]    n_lim;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    if (int'(seg_count_q) > psc_pkg::MAX_SEGMENTS) begin
      n_lim = psc_pkg::CNT_W'(psc_pkg::MAX_SEGMENTS);
    end else begin
      n_lim = psc_pkg::CNT_W'(seg_count_q);
    end
  end

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    drain_d     = drain_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.raddr = cnt_q[psc_pkg::IDX_W-1:0];
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.start = 1'b1;
          cmd_o.store = (in_func_i == psc_pkg::FUNC_LOAD);
          n_d         = n_lim;
          cnt_d       = '0;
          if (in_func_i == psc_pkg::FUNC_QUERY && n_lim != '0) begin
            state_d = ST_RUN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q + 1'b1 == n_q) begin
          drain_d = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_d = drain_q + 1'b1;
        if (drain_q == psc_pkg::DRAIN_W'(psc_pkg::PIPE_DEPTH - 1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seg_count_q <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
      drain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      cnt_q       <= cnt_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        seg_count_q <= cfg_wdata_i;
      end
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_load_skips_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_func_i == psc_pkg::FUNC_LOAD) |=> (state_q == ST_FINISH))
    else $error("load transaction did not go straight to result");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (cnt_q < n_q && n_q != '0))
    else $error("scan index beyond segment count");

  a_result_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_FINISH))
    else $error("result raised outside finish state");

  a_finish_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && $past(state_q) == ST_RUN) |-> 1'b0)
    else $error("finish entered before pipeline drained");
`endif

endmodule

### src/path_obstacle_segment_collision_core.sv
// sequence: a load, or a query with segment_count 0, goes from acceptance straight to
// the result step; any other query first scans min(segment_count, 64) table entries, one
// entering the four stage orientation pipeline per cycle, then the pipeline drains
// throughput: one transaction at a time; the next is accepted in the cycle after the
// result is registered, while that result may still be waiting downstream
// reset: control state and segment_count clear; table contents stay undefined until loaded
module path_obstacle_segment_collision_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [psc_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  psc_pkg::in_item_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output psc_pkg::out_item_t        out_data_o
);

  psc_pkg::psc_cmd_t cmd;

  psc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_func_i   (in_data_i.func),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  psc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

### bench/testbench.sv
// self-checking bench for path_obstacle_segment_collision_core: loads obstacle segments,
// queries paths against them and checks every result against an in-bench orientation predictor
// depends on psc_pkg and the core module
`timescale 1ns / 100ps

module testbench;
  import psc_pkg::*;

  typedef enum int {PT_WIDE, PT_GRID, PT_RIM} pt_mode_e;

  localparam int HOLD_AT    = 300;
  localparam int HOLD_LEN   = 400;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int CNT_RAND_SMALL = -1;
  localparam int CNT_RAND_FULL  = -2;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_item_t           in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;

  in_item_t  item_backlog [$];
  out_item_t hit_reports_q [$];
  seg_t      obstacle_tbl [MAX_SEGMENTS];
  logic [CFG_W-1:0] count_reg = '0;
  bit        gen_loaded [MAX_SEGMENTS];
  point_t    grid_center = '0;
  bit        calm = 1'b0;
  int        err_cnt = 0;
  int        reports_seen = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;

  int phase_cnt [10] = '{64, 127, 0, 1, 65, CNT_RAND_SMALL, CNT_RAND_SMALL, 8,
                         CNT_RAND_FULL, 2};

  path_obstacle_segment_collision_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [DIFF_W-1:0] widen(logic signed [COORD_BITS-1:0] v);
    return {v[COORD_BITS-1], v};
  endfunction

  function automatic orient_e turn_of(point_t p, point_t q, point_t r);
    logic signed [DIFF_W-1:0]  dqy, drx, dqx, dry;
    logic signed [PROD_W-1:0]  lhs, rhs;
    logic signed [CROSS_W-1:0] area2;
    dqy = widen(q.y) - widen(p.y);
    drx = widen(r.x) - widen(q.x);
    dqx = widen(q.x) - widen(p.x);
    dry = widen(r.y) - widen(q.y);
    lhs = dqy * drx;
    rhs = dqx * dry;
    area2 = lhs - rhs;
    if (area2 == 0) return OR_COLLINEAR;
    return (area2 < 0) ? OR_CCW : OR_CW;
  endfunction

  // q inside the bounding box of p and r
  function automatic bit on_box(point_t p, point_t q, point_t r);
    logic signed [COORD_BITS-1:0] px, py, qx, qy, rx, ry;
    px = p.x; py = p.y; qx = q.x; qy = q.y; rx = r.x; ry = r.y;
    return (qx <= ((px > rx) ? px : rx)) && (qx >= ((px < rx) ? px : rx)) &&
           (qy <= ((py > ry) ? py : ry)) && (qy >= ((py < ry) ? py : ry));
  endfunction

  function automatic bit path_meets(point_t p1, point_t q1, seg_t s);
    orient_e o1, o2, o3, o4;
    o1 = turn_of(p1, q1, s.a);
    o2 = turn_of(p1, q1, s.b);
    o3 = turn_of(s.a, s.b, p1);
    o4 = turn_of(s.a, s.b, q1);
    if (o1 != o2 && o3 != o4) return 1'b1;
    // collinear touches, degenerate segments included
    if (o1 == OR_COLLINEAR && on_box(p1, s.a, q1)) return 1'b1;
    if (o2 == OR_COLLINEAR && on_box(p1, s.b, q1)) return 1'b1;
    if (o3 == OR_COLLINEAR && on_box(s.a, p1, s.b)) return 1'b1;
    if (o4 == OR_COLLINEAR && on_box(s.a, q1, s.b)) return 1'b1;
    return 1'b0;
  endfunction

  task automatic predict_report(in_item_t it);
    out_item_t   rep;
    point_t      pa, pb;
    int unsigned n;
    rep = '0;
    pa.x = it.point_a_x;
    pa.y = it.point_a_y;
    pb.x = it.point_b_x;
    pb.y = it.point_b_y;
    if (it.func == FUNC_LOAD) begin
      if (it.slot < MAX_SEGMENTS) begin
        obstacle_tbl[it.slot].a = pa;
        obstacle_tbl[it.slot].b = pb;
      end
    end else begin
      n = (count_reg > MAX_SEGMENTS) ? MAX_SEGMENTS : count_reg;
      for (int i = 0; i < n; i++) begin
        if (path_meets(pa, pb, obstacle_tbl[i])) begin
          rep.collision = 1'b1;
          rep.hit_index = HIT_W'(i);
          break;
        end
      end
    end
    hit_reports_q = {hit_reports_q, rep};
  endtask

  // ---------------------------------------------------------------- stimulus helpers

  function automatic point_t pt(int x, int y);
    point_t p;
    p.x = 16'(x);
    p.y = 16'(y);
    return p;
  endfunction

  function automatic logic signed [15:0] rim_coord();
    case ($urandom_range(5))
      0:       return 16'sh8000;
      1:       return 16'sh8001;
      2:       return 16'sh7fff;
      3:       return 16'sh7ffe;
      4:       return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  function automatic point_t pick_point(pt_mode_e m);
    point_t p;
    case (m)
      PT_WIDE: begin
        p.x = 16'($urandom);
        p.y = 16'($urandom);
      end
      PT_GRID: begin
        // small cluster so touches, shared endpoints and collinear runs are common
        p.x = grid_center.x + 16'(int'($urandom_range(16)) - 8);
        p.y = grid_center.y + 16'(int'($urandom_range(16)) - 8);
      end
      default: begin
        p.x = rim_coord();
        p.y = rim_coord();
      end
    endcase
    return p;
  endfunction

  function automatic pt_mode_e pick_mode(int unsigned grid_pct, int unsigned wide_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < grid_pct) return PT_GRID;
    if (r < grid_pct + wide_pct) return PT_WIDE;
    return PT_RIM;
  endfunction

  task automatic queue_item(logic func, logic [SLOT_W-1:0] slot, point_t a, point_t b);
    in_item_t it;
    it.func      = func;
    it.slot      = slot;
    it.point_a_x = a.x;
    it.point_a_y = a.y;
    it.point_b_x = b.x;
    it.point_b_y = b.y;
    item_backlog = {item_backlog, it};
    if (func == FUNC_LOAD) gen_loaded[slot] = 1'b1;
  endtask

  // a query never reaches a table entry that has not been loaded
  task automatic queue_query(point_t a, point_t b);
    int unsigned n;
    n = (count_reg > MAX_SEGMENTS) ? MAX_SEGMENTS : count_reg;
    for (int i = 0; i < n; i++) begin
      if (!gen_loaded[i])
        queue_item(FUNC_LOAD, SLOT_W'(i), pick_point(PT_GRID), pick_point(PT_WIDE));
    end
    queue_item(FUNC_QUERY, SLOT_W'($urandom), a, b);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (item_backlog.size() != 0 || in_valid || hit_reports_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_count(logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    count_reg = v;
    @(negedge clk);
  endtask

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 32);
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_report(in_data);
      if (!in_valid || !in_stall) begin
        if (item_backlog.size() != 0 && !take_break()) begin
          in_data  <= item_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        reports_seen <= reports_seen + 1;
        if (hit_reports_q.size() == 0) begin
          $display("%0t: unexpected result collision %0b hit_index %0d", $time,
                   out_data.collision, out_data.hit_index);
          err_cnt++;
        end else begin
          want = hit_reports_q.pop_front();
          if (out_data.collision !== want.collision) begin
            $display("%0t: collision expected %0b actual %0b", $time,
                     want.collision, out_data.collision);
            err_cnt++;
          end
          if (out_data.hit_index !== want.hit_index) begin
            $display("%0t: hit_index expected %0d actual %0d", $time,
                     want.hit_index, out_data.hit_index);
            err_cnt++;
          end
        end
      end
      out_stall <= (hold_left != 0) || take_break();
    end
  end

  // one long hold-off on the result side so the core backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && reports_seen >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int               v;
    int unsigned      n_chk, lim;
    pt_mode_e         m;
    point_t           a, b;
    logic [SLOT_W-1:0] slot;

    // count is zero out of reset: the query scans no segment
    queue_query(pt(-32768, -32768), pt(32767, 32767));
    queue_item(FUNC_LOAD, 6'd0, pt(-32768, -32768), pt(32767, 32767));
    queue_item(FUNC_LOAD, 6'd1, pt(100, -50), pt(100, -50));
    queue_item(FUNC_LOAD, 6'd2, pt(0, 100), pt(200, 100));
    queue_item(FUNC_LOAD, 6'd3, pt(-300, 200), pt(-100, 200));
    queue_item(FUNC_LOAD, 6'd63, pt(32767, 32767), pt(-32768, -32768));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    write_count(7'd4);
    queue_query(pt(-32768, 32767), pt(32767, -32768));   // proper crossing
    queue_query(pt(100, -60), pt(100, -40));             // point segment on the path
    queue_query(pt(200, 100), pt(300, 150));             // shared endpoint
    queue_query(pt(250, 100), pt(400, 100));             // collinear, disjoint
    queue_query(pt(150, 100), pt(250, 100));             // collinear overlap
    queue_query(pt(-250, 200), pt(-250, 200));           // point path on a segment
    queue_query(pt(-200, 150), pt(-200, 250));
    queue_query(pt(-30000, 30000), pt(-29000, 30000));   // clear of everything
    queue_query(pt(-32768, -32768), pt(32767, 32767));   // full-range collinear
    queue_query(pt(32767, -32768), pt(32767, -32767));
    wait_drained();

    for (int ph = 0; ph < 10; ph++) begin
      if (phase_cnt[ph] == CNT_RAND_SMALL) v = $urandom_range(1, 20);
      else if (phase_cnt[ph] == CNT_RAND_FULL) v = $urandom_range(127);
      else v = phase_cnt[ph];
      write_count(CFG_W'(v));
      n_chk = (count_reg > MAX_SEGMENTS) ? MAX_SEGMENTS : count_reg;
      calm = (ph == 5);
      grid_center = pt(int'($urandom_range(64000)) - 32000,
                       int'($urandom_range(64000)) - 32000);
      repeat (ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 45) begin
          lim = (n_chk > 0 && $urandom_range(9) < 7) ? n_chk - 1 : MAX_SEGMENTS - 1;
          slot = SLOT_W'($urandom_range(lim));
          m = pick_mode(60, 25);
          a = pick_point(m);
          b = ($urandom_range(9) == 0) ? a : pick_point(m);
          queue_item(FUNC_LOAD, slot, a, b);
        end else begin
          m = pick_mode(75, 15);
          a = pick_point(m);
          b = ($urandom_range(9) == 0) ? a : pick_point(m);
          queue_query(a, b);
        end
      end
      wait_drained();
    end
    calm = 1'b0;

    repeat (80) @(posedge clk);
    if (err_cnt == 0) begin
      $display("path_obstacle_segment_collision_core test passed");
    end else begin
      $display("path_obstacle_segment_collision_core test failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("path_obstacle_segment_collision_core test failed");
    $finish;
  end

endmodule
